### hw/rtl/sov_pkg.sv
// Shared widths, constants and pipeline word types for the sphere overlap volume block.
package sov_pkg;

    // Field formats
    localparam int COORD_W   = 24;
    localparam int FRAC_BITS = 16;
    localparam int VOL_W     = 44;

    // Distance path
    localparam int DIFF_W = COORD_W;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int SQRT_W = SUM_W + 1;

    // Radius path
    localparam int RAD_W  = COORD_W;
    localparam int SUMR_W = RAD_W + 1;
    localparam int CUBE_W = 3 * RAD_W - 2 * FRAC_BITS;

    // Lens numerator and divisor
    localparam int D12_W  = ROOT_W + 4;
    localparam int Q_W    = 2 * SUMR_W + 2;
    localparam int QS_W   = Q_W - FRAC_BITS;
    localparam int T2_W   = 2 * SUMR_W - FRAC_BITS;
    localparam int QLO_W  = QS_W / 2;
    localparam int QHI_W  = QS_W - QLO_W;
    localparam int NUM_W  = T2_W + QS_W;

    // Quotient and pi scaling
    localparam int X_W      = VOL_W + 2;
    localparam int DIVC_W   = D12_W + X_W;
    localparam int XLO_W    = X_W / 2;
    localparam int XHI_W    = X_W - XLO_W;
    localparam int PI_W     = 32;
    localparam int PI_SHIFT = 30;
    localparam int PROD_W   = X_W + PI_W;
    localparam logic [PI_W-1:0] PI_Q = 32'd3373259426;

    typedef enum logic [1:0] {
        CASE_DISJOINT = 2'd0,
        CASE_CONTAIN  = 2'd1,
        CASE_LENS     = 2'd2
    } t_case;

    typedef struct packed {
        logic [SUMR_W-1:0] s;
        logic [RAD_W-1:0]  g;
        logic [CUBE_W-1:0] cube;
    } t_geo;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [D12_W-1:0] den;
        t_case            kind;
    } t_div_in;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic           ovf;
        t_case          kind;
    } t_div_out;

    typedef struct packed {
        logic [VOL_W-1:0] volume;
        t_case            kind;
        logic             sat;
    } t_result;

endpackage

### hw/rtl/sov_if.sv
// Valid/ready channel interfaces for sphere pair words and volume result words.
interface sov_in_if import sov_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] center_a_x;
    logic signed [COORD_W-1:0] center_a_y;
    logic signed [COORD_W-1:0] center_a_z;
    logic signed [COORD_W-1:0] center_b_x;
    logic signed [COORD_W-1:0] center_b_y;
    logic signed [COORD_W-1:0] center_b_z;
    logic [COORD_W-1:0]        radius_a;
    logic [COORD_W-1:0]        radius_b;

    modport source (
        output valid, center_a_x, center_a_y, center_a_z,
        output center_b_x, center_b_y, center_b_z, radius_a, radius_b,
        input  ready
    );
    modport sink (
        input  valid, center_a_x, center_a_y, center_a_z,
        input  center_b_x, center_b_y, center_b_z, radius_a, radius_b,
        output ready
    );
endinterface

interface sov_out_if import sov_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VOL_W-1:0] overlap_volume;
    logic [1:0]       overlap_case;
    logic             saturated;

    modport source (
        output valid, overlap_volume, overlap_case, saturated,
        input  ready
    );
    modport sink (
        input  valid, overlap_volume, overlap_case, saturated,
        output ready
    );
endinterface

### hw/rtl/sphere_overlap_volume.sv
// Top level of the sphere pair overlap volume pipeline.
// Accepts one sphere pair word per cycle while input ready is high and returns one volume
// word per pair, in order. The pipeline is made of the 25-stage square root, resolving
// one bit per stage, the 47-stage divider (an overflow pre-check stage, then one quotient bit per stage),
// plus three front stages, four case stages, two scaling stages and the output register.
// A stall on the output holds one extra word in a skid register before the input
// ready drops, so the whole pipeline freezes without losing or repeating words.
module sphere_overlap_volume import sov_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sov_in_if.sink     i_in,
    sov_out_if.source  o_out
);

    logic              w_en;
    logic              w_fr_v, w_sq_v, w_ln_v, w_dv_v, w_sc_v;
    logic [SUM_W-1:0]  w_sum;
    t_geo              w_fr_geo, w_sq_geo;
    logic [ROOT_W-1:0] w_root;
    t_div_in           w_div;
    t_div_out          w_quo;
    t_result           w_res;
    logic              w_take;
    logic              r_out_v, r_skid_v;
    t_result           r_out, r_skid;

    // Freeze the pipe only while the skid register holds a word
    assign w_en       = ~r_skid_v;
    assign i_in.ready = w_en;
    assign w_take     = w_sc_v & w_en;

    sov_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_ax    (i_in.center_a_x),
        .i_ay    (i_in.center_a_y),
        .i_az    (i_in.center_a_z),
        .i_bx    (i_in.center_b_x),
        .i_by    (i_in.center_b_y),
        .i_bz    (i_in.center_b_z),
        .i_ra    (i_in.radius_a),
        .i_rb    (i_in.radius_b),
        .o_valid (w_fr_v),
        .o_sum   (w_sum),
        .o_geo   (w_fr_geo)
    );

    sov_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_v),
        .i_sum   (w_sum),
        .i_geo   (w_fr_geo),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_geo   (w_sq_geo)
    );

    sov_lens u_lens (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_v),
        .i_d     (w_root),
        .i_geo   (w_sq_geo),
        .o_valid (w_ln_v),
        .o_div   (w_div)
    );

    sov_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_ln_v),
        .i_div   (w_div),
        .o_valid (w_dv_v),
        .o_quo   (w_quo)
    );

    sov_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv_v),
        .i_quo   (w_quo),
        .o_valid (w_sc_v),
        .o_res   (w_res)
    );

    // Output register with skid: drain skid first, park a word when stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_out.ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= w_take;
            end
        end else if (w_take) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_out.ready) begin
            r_out <= r_skid_v ? r_skid : w_res;
        end else if (w_take) begin
            r_skid <= w_res;
        end
    end

    assign o_out.valid          = r_out_v;
    assign o_out.overlap_volume = r_out.volume;
    assign o_out.overlap_case   = r_out.kind;
    assign o_out.saturated      = r_out.sat;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held with empty output register");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !o_out.ready) |=> r_skid_v)
        else $error("skid word dropped while output stalled");

    a_disjoint_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overlap_case == CASE_DISJOINT) |->
        (o_out.overlap_volume == '0 && !o_out.saturated))
        else $error("disjoint pair with nonzero volume");

    a_contain_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overlap_case == CASE_CONTAIN) |-> !o_out.saturated)
        else $error("containment volume saturated");

    a_sat_is_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |-> (&o_out.overlap_volume))
        else $error("saturated volume not at maximum");

endmodule

### hw/rtl/sov_front.sv
// Front stages: coordinate differences, squared distance and the smaller-sphere cube.
module sov_front import sov_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [COORD_W-1:0] i_ax,
    input  logic signed [COORD_W-1:0] i_ay,
    input  logic signed [COORD_W-1:0] i_az,
    input  logic signed [COORD_W-1:0] i_bx,
    input  logic signed [COORD_W-1:0] i_by,
    input  logic signed [COORD_W-1:0] i_bz,
    input  logic [RAD_W-1:0]          i_ra,
    input  logic [RAD_W-1:0]          i_rb,
    output logic                      o_valid,
    output logic [SUM_W-1:0]          o_sum,
    output t_geo                      o_geo
);

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] diff;
        diff = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        return diff[COORD_W] ? DIFF_W'(-diff) : DIFF_W'(diff);
    endfunction

    logic                r_v1, r_v2, r_v3;
    logic [DIFF_W-1:0]   r_dx, r_dy, r_dz;
    logic [SUMR_W-1:0]   r_s1, r_s2, r_s3;
    logic [RAD_W-1:0]    r_g1, r_g2, r_g3;
    logic [RAD_W-1:0]    r_rmin1, r_rmin2;
    logic [SQ_W-1:0]     r_sqx, r_sqy, r_sqz, r_rr;
    logic [SUM_W-1:0]    r_sum;
    logic [CUBE_W-1:0]   r_cube;
    logic [3*RAD_W-FRAC_BITS-1:0] w_cc;

    // Second cube factor: (rmin^2 >> F) * rmin
    assign w_cc = r_rr[SQ_W-1:FRAC_BITS] * r_rmin2;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Differences, squares, sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx    <= abs_diff(i_ax, i_bx);
            r_dy    <= abs_diff(i_ay, i_by);
            r_dz    <= abs_diff(i_az, i_bz);
            r_s1    <= SUMR_W'(i_ra) + SUMR_W'(i_rb);
            r_g1    <= (i_ra > i_rb) ? i_ra - i_rb : i_rb - i_ra;
            r_rmin1 <= (i_ra < i_rb) ? i_ra : i_rb;

            r_sqx   <= r_dx * r_dx;
            r_sqy   <= r_dy * r_dy;
            r_sqz   <= r_dz * r_dz;
            r_rr    <= r_rmin1 * r_rmin1;
            r_s2    <= r_s1;
            r_g2    <= r_g1;
            r_rmin2 <= r_rmin1;

            r_sum   <= SUM_W'(r_sqx) + SUM_W'(r_sqy) + SUM_W'(r_sqz);
            r_cube  <= w_cc[3*RAD_W-FRAC_BITS-1:FRAC_BITS];
            r_s3    <= r_s2;
            r_g3    <= r_g2;
        end
    end

    assign o_valid     = r_v3;
    assign o_sum       = r_sum;
    assign o_geo.s     = r_s3;
    assign o_geo.g     = r_g3;
    assign o_geo.cube  = r_cube;

endmodule

### hw/rtl/sov_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module sov_isqrt import sov_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SUM_W-1:0]  i_sum,
    input  t_geo              i_geo,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_geo              o_geo
);

    logic [ROOT_W:0]   w_v;
    logic [SQRT_W-1:0] w_op  [ROOT_W+1];
    logic [SQRT_W-1:0] w_res [ROOT_W+1];
    t_geo              w_geo [ROOT_W+1];

    assign w_v[0]   = i_valid;
    assign w_op[0]  = SQRT_W'(i_sum);
    assign w_res[0] = '0;
    assign w_geo[0] = i_geo;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              r_v;
        logic [SQRT_W-1:0] r_op;
        logic [SQRT_W-1:0] r_res;
        t_geo              r_geo;
        logic [SQRT_W-1:0] w_one;
        logic [SQRT_W-1:0] w_trial;
        logic              w_take;

        // Try the next root bit against the remainder
        assign w_one   = SQRT_W'(1) << (2 * (ROOT_W - 1 - k));
        assign w_trial = w_res[k] + w_one;
        assign w_take  = (w_op[k] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_op  <= w_take ? w_op[k] - w_trial : w_op[k];
                r_res <= w_take ? (w_res[k] >> 1) + w_one : (w_res[k] >> 1);
                r_geo <= w_geo[k];
            end
        end

        assign w_v[k+1]   = r_v;
        assign w_op[k+1]  = r_op;
        assign w_res[k+1] = r_res;
        assign w_geo[k+1] = r_geo;
    end

    assign o_valid = w_v[ROOT_W] & (w_op[ROOT_W] == w_op[ROOT_W] ? 1'b1 : 1'b1);
    assign o_root  = w_res[ROOT_W][ROOT_W-1:0];
    assign o_geo   = w_geo[ROOT_W];

endmodule

### hw/rtl/sov_lens.sv
// Case decision and numerator/divisor build for the containment and lens volumes.
module sov_lens import sov_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [ROOT_W-1:0] i_d,
    input  t_geo              i_geo,
    output logic              o_valid,
    output t_div_in           o_div
);

    logic                  r_v1, r_v2, r_v3, r_v4;
    t_case                 r_k1, r_k2, r_k3;
    logic [2*ROOT_W-1:0]   r_dd;
    logic [ROOT_W+SUMR_W-1:0] r_ds;
    logic [2*RAD_W-1:0]    r_gg;
    logic [SUMR_W-1:0]     r_t;
    logic [D12_W-1:0]      r_d12_1, r_d12_2, r_d12_3;
    logic [CUBE_W-1:0]     r_cube1, r_cube2, r_cube3;
    logic [Q_W-1:0]        r_q;
    logic [2*SUMR_W-1:0]   r_tt;
    logic [T2_W+QLO_W-1:0] r_plo;
    logic [T2_W+QHI_W-1:0] r_phi;
    t_div_in               r_out;
    t_case                 w_kind;
    logic [T2_W-1:0]       w_t2;
    logic [QS_W-1:0]       w_qs;
    logic [NUM_W-1:0]      w_num;

    // Sort into disjoint, containment or lens
    always_comb begin
        if (SUMR_W'(i_d) > i_geo.s) begin
            w_kind = CASE_DISJOINT;
        end else if (SUMR_W'(i_d) <= SUMR_W'(i_geo.g)) begin
            w_kind = CASE_CONTAIN;
        end else begin
            w_kind = CASE_LENS;
        end
    end

    assign w_t2  = r_tt[2*SUMR_W-1:FRAC_BITS];
    assign w_qs  = r_q[Q_W-1:FRAC_BITS];
    assign w_num = NUM_W'(r_plo) + {r_phi, {QLO_W{1'b0}}};

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Products of distance and radii
            r_k1    <= w_kind;
            r_dd    <= i_d * i_d;
            r_ds    <= i_d * i_geo.s;
            r_gg    <= i_geo.g * i_geo.g;
            r_t     <= i_geo.s - SUMR_W'(i_d);
            r_d12_1 <= D12_W'({i_d, 3'b000}) + D12_W'({i_d, 2'b00});
            r_cube1 <= i_geo.cube;

            // q = d^2 + 2ds - 3g^2 and t^2
            r_k2    <= r_k1;
            r_q     <= Q_W'(r_dd) + Q_W'({r_ds, 1'b0}) - Q_W'({r_gg, 1'b0}) - Q_W'(r_gg);
            r_tt    <= r_t * r_t;
            r_d12_2 <= r_d12_1;
            r_cube2 <= r_cube1;

            // Split product (t^2 >> F) * (q >> F)
            r_k3    <= r_k2;
            r_plo   <= w_t2 * w_qs[QLO_W-1:0];
            r_phi   <= w_t2 * w_qs[QS_W-1:QLO_W];
            r_d12_3 <= r_d12_2;
            r_cube3 <= r_cube2;

            // Pick the dividend and divisor for this case
            r_out.kind <= r_k3;
            case (r_k3)
                CASE_CONTAIN: begin
                    r_out.num <= NUM_W'({r_cube3, 2'b00});
                    r_out.den <= D12_W'(3);
                end
                CASE_LENS: begin
                    r_out.num <= w_num;
                    r_out.den <= r_d12_3;
                end
                default: begin
                    r_out.num <= '0;
                    r_out.den <= D12_W'(1);
                end
            endcase
        end
    end

    assign o_valid = r_v4;
    assign o_div   = r_out;

endmodule

### hw/rtl/sov_div.sv
// Pipelined restoring divider, one quotient bit per stage, with an overflow pre-check.
module sov_div import sov_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_div_in  i_div,
    output logic     o_valid,
    output t_div_out o_quo
);

    logic             w_v    [X_W+1];
    logic [NUM_W-1:0] w_rem  [X_W+1];
    logic [D12_W-1:0] w_den  [X_W+1];
    logic [X_W-1:0]   w_q    [X_W+1];
    logic             w_ovf  [X_W+1];
    t_case            w_kind [X_W+1];

    logic             r_v0;
    logic [NUM_W-1:0] r_rem0;
    logic [D12_W-1:0] r_den0;
    logic             r_ovf0;
    t_case            r_kind0;

    // Flag quotients too large for the volume range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0  <= i_div.num;
            r_den0  <= i_div.den;
            r_ovf0  <= DIVC_W'(i_div.num) >= {i_div.den, {X_W{1'b0}}};
            r_kind0 <= i_div.kind;
        end
    end

    assign w_v[0]    = r_v0;
    assign w_rem[0]  = r_rem0;
    assign w_den[0]  = r_den0;
    assign w_q[0]    = '0;
    assign w_ovf[0]  = r_ovf0;
    assign w_kind[0] = r_kind0;

    for (genvar k = 0; k < X_W; k++) begin : g_stage
        logic              r_v;
        logic [NUM_W-1:0]  r_rem;
        logic [D12_W-1:0]  r_den;
        logic [X_W-1:0]    r_q;
        logic              r_ovf;
        t_case             r_kind;
        logic [DIVC_W-1:0] w_sh;
        logic              w_take;

        // Subtract the shifted divisor where it fits
        assign w_sh   = DIVC_W'(w_den[k]) << (X_W - 1 - k);
        assign w_take = (DIVC_W'(w_rem[k]) >= w_sh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_take ? w_rem[k] - w_sh[NUM_W-1:0] : w_rem[k];
                r_q    <= w_take ? (w_q[k] | (X_W'(1) << (X_W - 1 - k))) : w_q[k];
                r_den  <= w_den[k];
                r_ovf  <= w_ovf[k];
                r_kind <= w_kind[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_rem[k+1]  = r_rem;
        assign w_den[k+1]  = r_den;
        assign w_q[k+1]    = r_q;
        assign w_ovf[k+1]  = r_ovf;
        assign w_kind[k+1] = r_kind;
    end

    assign o_valid   = w_v[X_W];
    assign o_quo.x   = w_q[X_W];
    assign o_quo.ovf = w_ovf[X_W] | ((w_rem[X_W] != w_rem[X_W]) & (w_den[X_W] != '0));
    assign o_quo.kind = w_kind[X_W];

endmodule

### hw/rtl/sov_scale.sv
// Pi scaling of the quotient and saturation to the volume width.
module sov_scale import sov_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_div_out i_quo,
    output logic     o_valid,
    output t_result  o_res
);

    logic                   r_v1, r_v2;
    logic [XLO_W+PI_W-1:0]  r_p0;
    logic [XHI_W+PI_W-1:0]  r_p1;
    logic                   r_ovf;
    t_case                  r_kind;
    t_result                r_res;
    logic [PROD_W-1:0]      w_prod;
    logic [PROD_W-PI_SHIFT-1:0] w_vol;
    logic                   w_sat;

    // Join the partial products and clip
    assign w_prod = PROD_W'(r_p0) + {r_p1, {XLO_W{1'b0}}};
    assign w_vol  = w_prod[PROD_W-1:PI_SHIFT];
    assign w_sat  = r_ovf | (|w_vol[PROD_W-PI_SHIFT-1:VOL_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0   <= i_quo.x[XLO_W-1:0] * PI_Q;
            r_p1   <= i_quo.x[X_W-1:XLO_W] * PI_Q;
            r_ovf  <= i_quo.ovf;
            r_kind <= i_quo.kind;

            r_res.volume <= w_sat ? {VOL_W{1'b1}} : w_vol[VOL_W-1:0];
            r_res.sat    <= w_sat;
            r_res.kind   <= r_kind;
        end
    end

    assign o_valid = r_v2;
    assign o_res   = r_res;

endmodule
